@@ rtl/rsc_pkg.sv @@
// shared types and constants of the recursive systematic convolutional encoder
package rsc_pkg;

	// widths of the configuration registers
	localparam int POLY_W    = 5;
	localparam int PAT_W     = 16;
	localparam int PERIOD_W  = 5;
	localparam int POS_W     = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	// polynomial bits above bit 0 that reach a register stage
	localparam int TAP_BITS = POLY_W - 1;

	// stream widths
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 8;
	localparam int MODE_W     = 2;

	// input item modes
	localparam logic [MODE_W-1:0] MODE_DATA = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TERM = 2'd1;
	localparam logic [MODE_W-1:0] MODE_END  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FF_POLY = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FB_POLY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_A   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_B   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_SEL = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 3'd5;

	// register reset values
	localparam logic [POLY_W-1:0]   FF_POLY_RST = 5'd31;
	localparam logic [POLY_W-1:0]   FB_POLY_RST = 5'd19;
	localparam logic [PAT_W-1:0]    PAT_RST     = 16'hFFFF;
	localparam logic [PERIOD_W-1:0] PERIOD_RST  = 5'd1;
	localparam logic [PERIOD_W-1:0] PERIOD_MAX  = 5'd16;

	// control shared by all register cells
	typedef struct packed {
		logic shift;
		logic clear;
	} rsc_ctl_t;

endpackage

@@ rtl/rsc_cell.sv @@
// one stage of the encoder shift register with its tap contributions
module rsc_cell
	import rsc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  rsc_ctl_t ctl,
	input  logic     shift_in,
	input  logic     fb_tap,
	input  logic     ff_tap,
	input  logic     fb_acc_in,
	input  logic     ff_acc_in,
	output logic     stage,
	output logic     fb_acc_out,
	output logic     ff_acc_out
);

	logic stage_q;

	// stage bit, cleared at end of frame, shifted on each encoded bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= 1'b0;
		end else if (ctl.clear) begin
			stage_q <= 1'b0;
		end else if (ctl.shift) begin
			stage_q <= shift_in;
		end
	end

	// running xor of tapped stages along the row
	assign fb_acc_out = fb_acc_in ^ (fb_tap & stage_q);
	assign ff_acc_out = ff_acc_in ^ (ff_tap & stage_q);
	assign stage      = stage_q;

endmodule

@@ rtl/rsc_punct.sv @@
// frame position counter and puncture mask bit selection
module rsc_punct
	import rsc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic [PAT_W-1:0]    pattern,
	input  logic [PERIOD_W-1:0] period,
	input  logic                advance,
	input  logic                clear,
	output logic                kept
);

	logic [POS_W-1:0]    pos_q;
	logic [PERIOD_W-1:0] period_eff;
	logic [POS_W-1:0]    pos_cur;
	logic [PERIOD_W-1:0] pos_inc;
	logic [POS_W-1:0]    pos_next;

	// period clamped to 1..16, position folded to 0 when past the period
	always_comb begin
		if (period == '0) begin
			period_eff = PERIOD_W'(1);
		end else if (period > PERIOD_MAX) begin
			period_eff = PERIOD_MAX;
		end else begin
			period_eff = period;
		end
		pos_cur  = ({1'b0, pos_q} < period_eff) ? pos_q : '0;
		pos_inc  = {1'b0, pos_cur} + PERIOD_W'(1);
		pos_next = (pos_inc >= period_eff) ? '0 : pos_inc[POS_W-1:0];
	end

	assign kept = pattern[pos_cur];

	// position register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (clear) begin
			pos_q <= '0;
		end else if (advance) begin
			pos_q <= pos_next;
		end
	end

endmodule

@@ rtl/rsc_encoder_punctured_tail.sv @@
// top level of the recursive systematic convolutional encoder with puncture marking
//
// Input stream s_*: one item per transfer, s_tdata[1:0] = mode, s_tdata[2] = data bit.
// Mode 0 encodes one bit and gives one result; mode 1 terminates the frame and
// gives MEMORY_LENGTH tail results; mode 2 clears state and position without result;
// mode 3 is taken and ignored.
// Output stream m_*: one result per transfer, m_tdata holds systematic, parity and
// parity-kept bits, m_tuser marks a tail result, m_tlast marks the final result
// of the input item.
// The first result of an input transfer is registered in the output register.
// Data bits sustain one item per cycle while the receiver keeps up; a terminate item
// holds the input until its MEMORY_LENGTH tail results are made, paced by the tail counter.
// The shift register is a row of MEMORY_LENGTH cells whose taps are xored along the
// row in the same cycle.
// Reset clears the register cells, the frame position, the tail counter and the
// output valid flag, and loads the configuration registers with their reset values.
// When the receiver stalls, the result holds in the output register and s_tready
// drops until it is taken. Configuration is written through cfg_we/cfg_addr/cfg_wdata.
module rsc_encoder_punctured_tail
	import rsc_pkg::*;
#(
	parameter int MEMORY_LENGTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DAT_W-1:0]  cfg_wdata,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // mode[1:0], data_bit[2], zero fill
	// output stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // systematic_bit[0], parity_bit[1], parity_kept[2]
	output logic                  m_tuser,   // is_tail
	output logic                  m_tlast
);

	localparam int CNT_W = $clog2(MEMORY_LENGTH + 1);

	// configuration registers
	logic [POLY_W-1:0]   ff_poly_q;
	logic [POLY_W-1:0]   fb_poly_q;
	logic [PAT_W-1:0]    pat_a_q;
	logic [PAT_W-1:0]    pat_b_q;
	logic                pat_sel_q;
	logic [PERIOD_W-1:0] period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ff_poly_q <= FF_POLY_RST;
			fb_poly_q <= FB_POLY_RST;
			pat_a_q   <= PAT_RST;
			pat_b_q   <= PAT_RST;
			pat_sel_q <= 1'b0;
			period_q  <= PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_FF_POLY: ff_poly_q <= cfg_wdata[POLY_W-1:0];
				CFG_FB_POLY: fb_poly_q <= cfg_wdata[POLY_W-1:0];
				CFG_PAT_A:   pat_a_q   <= cfg_wdata[PAT_W-1:0];
				CFG_PAT_B:   pat_b_q   <= cfg_wdata[PAT_W-1:0];
				CFG_PAT_SEL: pat_sel_q <= cfg_wdata[0];
				CFG_PERIOD:  period_q  <= cfg_wdata[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake and step decode
	logic [CNT_W-1:0]  tail_cnt_q;
	logic              tail_busy;
	logic              out_free;
	logic              in_xfer;
	logic [MODE_W-1:0] in_mode;
	logic              in_bit;
	logic              step_data;
	logic              step_term;
	logic              step_tail_more;
	logic              step_tail;
	logic              step;
	logic              frame_end;
	logic [CNT_W-1:0]  tail_rem;

	assign in_mode        = s_tdata[MODE_W-1:0];
	assign in_bit         = s_tdata[MODE_W];
	assign tail_busy      = (tail_cnt_q != '0);
	assign out_free       = !m_tvalid || m_tready;
	assign s_tready       = !tail_busy && out_free;
	assign in_xfer        = s_tvalid && s_tready;
	assign step_data      = in_xfer && (in_mode == MODE_DATA);
	assign step_term      = in_xfer && (in_mode == MODE_TERM);
	assign frame_end      = in_xfer && (in_mode == MODE_END);
	assign step_tail_more = tail_busy && out_free;
	assign step_tail      = step_term || step_tail_more;
	assign step           = step_data || step_tail;

	// tail results still owed after this cycle
	always_comb begin
		if (step_term) begin
			tail_rem = CNT_W'(MEMORY_LENGTH - 1);
		end else if (step_tail_more) begin
			tail_rem = tail_cnt_q - CNT_W'(1);
		end else begin
			tail_rem = tail_cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_cnt_q <= '0;
		end else begin
			tail_cnt_q <= tail_rem;
		end
	end

	// row of register cells
	rsc_ctl_t               cell_ctl;
	logic [MEMORY_LENGTH-1:0] stage;
	logic [MEMORY_LENGTH:0]   fb_chain;
	logic [MEMORY_LENGTH:0]   ff_chain;
	logic                     fb_tapped;
	logic                     sys_bit;
	logic                     fb_bit;
	logic                     par_bit;

	assign cell_ctl.shift = step;
	assign cell_ctl.clear = frame_end;
	assign fb_chain[0]    = 1'b0;
	assign ff_chain[0]    = 1'b0;

	for (genvar i = 0; i < MEMORY_LENGTH; i++) begin : g_cell
		logic shift_in;
		logic fb_tap;
		logic ff_tap;

		if (i == 0) begin : g_head
			assign shift_in = fb_bit;
		end else begin : g_body
			assign shift_in = stage[i-1];
		end

		if (i < TAP_BITS) begin : g_tap
			assign fb_tap = fb_poly_q[i+1];
			assign ff_tap = ff_poly_q[i+1];
		end else begin : g_notap
			assign fb_tap = 1'b0;
			assign ff_tap = 1'b0;
		end

		rsc_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (cell_ctl),
			.shift_in   (shift_in),
			.fb_tap     (fb_tap),
			.ff_tap     (ff_tap),
			.fb_acc_in  (fb_chain[i]),
			.ff_acc_in  (ff_chain[i]),
			.stage      (stage[i]),
			.fb_acc_out (fb_chain[i+1]),
			.ff_acc_out (ff_chain[i+1])
		);
	end

	// feedback and parity; a tail bit equals the tapped sum so feedback is zero
	assign fb_tapped = fb_chain[MEMORY_LENGTH];
	assign sys_bit   = step_tail ? fb_tapped : in_bit;
	assign fb_bit    = sys_bit ^ fb_tapped;
	assign par_bit   = (ff_poly_q[0] & fb_bit) ^ ff_chain[MEMORY_LENGTH];

	// puncture position and mask bit
	logic kept_bit;

	rsc_punct u_punct (
		.clk     (clk),
		.arst_n  (arst_n),
		.pattern (pat_sel_q ? pat_b_q : pat_a_q),
		.period  (period_q),
		.advance (step_data),
		.clear   (frame_end || step_term),
		.kept    (kept_bit)
	);

	// output register
	logic m_tvalid_q;
	logic sys_q;
	logic par_q;
	logic kept_q;
	logic tail_q;
	logic last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (step) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			sys_q  <= sys_bit;
			par_q  <= par_bit;
			kept_q <= step_tail ? 1'b1 : kept_bit;
			tail_q <= step_tail;
			last_q <= step_data || (tail_rem == '0);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_DATA_W - 3){1'b0}}, kept_q, par_q, sys_q};
	assign m_tuser  = tail_q;
	assign m_tlast  = last_q;

endmodule

@@ test/rsc_checker.sv @@
// checker for the convolutional encoder: watches both streams, predicts results, compares
module rsc_checker
	import rsc_pkg::*;
#(
	parameter int MEM_LEN = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DAT_W-1:0]  cfg_wdata,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // mode[1:0], data_bit[2], zero fill
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,   // systematic_bit[0], parity_bit[1], parity_kept[2]
	input  logic                  m_tuser,   // is_tail
	input  logic                  m_tlast,
	output int                    fail_count,
	output int                    pending,
	output int                    results_seen,
	output int                    tail_seen
);

	// one encoded output bit group
	typedef struct packed {
		logic sys;
		logic par;
		logic kept;
		logic tail;
		logic last;
	} enc_result_t;

	enc_result_t expected_bits[$];

	// shadow of the configuration registers
	logic [POLY_W-1:0]   ff_poly;
	logic [POLY_W-1:0]   fb_poly;
	logic [PAT_W-1:0]    pat_a;
	logic [PAT_W-1:0]    pat_b;
	logic                pat_sel;
	logic [PERIOD_W-1:0] period;

	// encoder state
	logic [MEM_LEN-1:0] sreg;
	int                 frame_pos;

	int n_fail = 0;
	int n_pending = 0;
	int n_results = 0;
	int n_tail = 0;

	assign fail_count   = n_fail;
	assign pending      = n_pending;
	assign results_seen = n_results;
	assign tail_seen    = n_tail;

	task automatic flag_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		n_fail++;
	endtask

	task automatic check_field(input string name, input logic got, input logic want);
		if (got !== want)
			flag_mismatch($sformatf("%s is %b, expected %b", name, got, want));
	endtask

	// xor of the register stages picked by a polynomial, bit 0 excluded
	function automatic logic stage_taps(input logic [POLY_W-1:0] poly);
		return ^((32'(poly) >> 1) & 32'(sreg));
	endfunction

	// clock one bit into the register, give back its parity
	function automatic logic shift_in(input logic b);
		logic fb;
		logic p;
		fb = b ^ stage_taps(fb_poly);
		p = (ff_poly[0] & fb) ^ stage_taps(ff_poly);
		sreg = (sreg << 1) | MEM_LEN'(fb);
		return p;
	endfunction

	// predict the results of one accepted input item
	task automatic encode_item(input logic [MODE_W-1:0] mode, input logic din);
		int          per;
		int          pos;
		int          j;
		logic [PAT_W-1:0] pat;
		logic        tb;
		enc_result_t r;
		case (mode)
			MODE_DATA: begin
				per = (period == 0) ? 1 : ((period > PERIOD_MAX) ? int'(PERIOD_MAX) : int'(period));
				pos = (frame_pos < per) ? frame_pos : 0;
				pat = pat_sel ? pat_b : pat_a;
				r.kept = pat[pos];
				r.sys = din;
				r.par = shift_in(din);
				r.tail = 1'b0;
				r.last = 1'b1;
				expected_bits.push_back(r);
				frame_pos = (pos + 1 >= per) ? 0 : pos + 1;
			end
			MODE_TERM: begin
				for (j = 0; j < MEM_LEN; j++) begin
					tb = stage_taps(fb_poly);
					r.sys = tb;
					r.par = shift_in(tb);
					r.kept = 1'b1;
					r.tail = 1'b1;
					r.last = (j == MEM_LEN - 1);
					expected_bits.push_back(r);
				end
				frame_pos = 0;
			end
			MODE_END: begin
				sreg = '0;
				frame_pos = 0;
			end
			default: ;
		endcase
	endtask

	// per edge: output transfer first, then register write, then input transfer
	always @(posedge clk or negedge arst_n) begin
		enc_result_t want;
		if (!arst_n) begin
			ff_poly = FF_POLY_RST;
			fb_poly = FB_POLY_RST;
			pat_a = PAT_RST;
			pat_b = PAT_RST;
			pat_sel = 1'b0;
			period = PERIOD_RST;
			sreg = '0;
			frame_pos = 0;
			expected_bits.delete();
			n_pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_bits.size() == 0) begin
					flag_mismatch("result transfer with nothing expected");
				end else begin
					want = expected_bits.pop_front();
					check_field("systematic_bit", m_tdata[0], want.sys);
					check_field("parity_bit", m_tdata[1], want.par);
					check_field("parity_kept", m_tdata[2], want.kept);
					check_field("is_tail", m_tuser, want.tail);
					check_field("last", m_tlast, want.last);
					if (m_tdata[OUT_DATA_W-1:3] !== '0)
						flag_mismatch($sformatf("fill bits of m_tdata are %b",
							m_tdata[OUT_DATA_W-1:3]));
					n_results++;
					if (want.tail)
						n_tail++;
				end
			end
			if (cfg_we) begin
				case (cfg_addr)
					CFG_FF_POLY: ff_poly = cfg_wdata[POLY_W-1:0];
					CFG_FB_POLY: fb_poly = cfg_wdata[POLY_W-1:0];
					CFG_PAT_A:   pat_a = cfg_wdata[PAT_W-1:0];
					CFG_PAT_B:   pat_b = cfg_wdata[PAT_W-1:0];
					CFG_PAT_SEL: pat_sel = cfg_wdata[0];
					CFG_PERIOD:  period = cfg_wdata[PERIOD_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				encode_item(s_tdata[MODE_W-1:0], s_tdata[MODE_W]);
			n_pending = expected_bits.size();
		end
	end

endmodule

@@ test/testbench.sv @@
// stimulus and verdict for the punctured convolutional encoder with tail termination
module testbench;
	import rsc_pkg::*;

	localparam int MEM_LEN      = 4;
	localparam int PHASE_ITEMS  = 20;
	localparam int DRAIN_CYCLES = 2 * MEM_LEN + 4;
	localparam int HOLD_CYCLES  = 60;

	// codes the package leaves unnamed
	localparam logic [MODE_W-1:0]    MODE_NONE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NONE6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_NONE7 = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_addr = '0;
	logic [CFG_DAT_W-1:0]  cfg_wdata = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;

	int fail_count;
	int pending;
	int results_seen;
	int tail_seen;

	// handshake pressure, written by the main process only
	int   src_idle = 0;
	int   sink_stall = 0;
	logic hold_armed = 1'b0;
	int   n_items = 0;
	int   n_settings = 0;

	rsc_encoder_punctured_tail #(
		.MEMORY_LENGTH(MEM_LEN)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	rsc_checker #(
		.MEM_LEN(MEM_LEN)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.fail_count(fail_count),
		.pending(pending),
		.results_seen(results_seen),
		.tail_seen(tail_seen)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random stalls, plus one long hold-off when armed
	always @(negedge clk) begin
		static int  hold_cnt = 0;
		static bit  hold_done = 1'b0;
		if (hold_armed && !hold_done) begin
			m_tready <= 1'b0;
			hold_cnt++;
			if (hold_cnt >= HOLD_CYCLES)
				hold_done = 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_stall);
		end
	end

	// offer one item after a random gap, return at the falling edge after its transfer
	task automatic send_item(input logic [MODE_W-1:0] mode, input logic din);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			s_tdata <= IN_DATA_W'($urandom);
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_DATA_W - MODE_W - 1){1'b0}}, din, mode};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		if (mode != MODE_NONE)
			n_items++;
	endtask

	// stop offering and let every expected result come out
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// one register write, write enable left high for the caller to lower
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(negedge clk);
	endtask

	// run limit
	initial begin
		#1000000;
		$display("Test completed with failures");
		$finish;
	end

	// main stimulus
	initial begin
		int ph;
		int sent;
		int flen;
		int roll;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset settings, a short frame and its tail
		send_item(MODE_DATA, 1'b1);
		send_item(MODE_DATA, 1'b0);
		send_item(MODE_DATA, 1'b1);
		send_item(MODE_DATA, 1'b1);
		send_item(MODE_TERM, 1'b1);

		// zero polynomials, every data parity punctured, longest period, unused indexes
		drain_results();
		cfg_write(CFG_FF_POLY, 16'h0000);
		cfg_write(CFG_FB_POLY, 16'hFFE0);
		cfg_write(CFG_PAT_A, 16'h0000);
		cfg_write(CFG_PERIOD, 16'd16);
		cfg_write(CFG_NONE6, 16'hFFFF);
		cfg_write(CFG_NONE7, 16'hFFFF);
		cfg_we <= 1'b0;
		n_settings++;
		send_item(MODE_DATA, 1'b1);
		send_item(MODE_DATA, 1'b1);
		send_item(MODE_DATA, 1'b0);
		send_item(MODE_NONE, 1'b1);
		send_item(MODE_END, 1'b1);
		send_item(MODE_DATA, 1'b1);
		send_item(MODE_TERM, 1'b0);

		// full polynomials, pattern b, period zero acting as one
		drain_results();
		cfg_write(CFG_FF_POLY, 16'h001F);
		cfg_write(CFG_FB_POLY, 16'h001F);
		cfg_write(CFG_PAT_B, 16'hA5A5);
		cfg_write(CFG_PAT_SEL, 16'hFFFF);
		cfg_write(CFG_PERIOD, 16'h0000);
		cfg_we <= 1'b0;
		n_settings++;
		send_item(MODE_DATA, 1'b1);
		send_item(MODE_DATA, 1'b0);

		// period above the pattern length acts as the longest one
		drain_results();
		cfg_write(CFG_PERIOD, 16'hFFFF);
		cfg_we <= 1'b0;
		n_settings++;
		send_item(MODE_DATA, 1'b1);
		send_item(MODE_DATA, 1'b1);
		send_item(MODE_DATA, 1'b0);

		// period shrinks below the current position
		drain_results();
		cfg_write(CFG_PERIOD, 16'd2);
		cfg_we <= 1'b0;
		n_settings++;
		send_item(MODE_DATA, 1'b0);
		send_item(MODE_DATA, 1'b1);
		send_item(MODE_TERM, 1'b1);

		// random frames under four handshake phases, new settings each phase
		for (ph = 0; ph < 4; ph++) begin
			drain_results();
			case (ph)
				0: begin src_idle = 0;  sink_stall = 0;  end
				1: begin src_idle = 76; sink_stall = 0;  end
				2: begin src_idle = 0;  sink_stall = 76; end
				default: begin src_idle = 35; sink_stall = 35; end
			endcase
			cfg_write(CFG_FF_POLY, CFG_DAT_W'($urandom));
			cfg_write(CFG_FB_POLY, CFG_DAT_W'($urandom));
			cfg_write(CFG_PAT_A, CFG_DAT_W'($urandom));
			cfg_write(CFG_PAT_B, CFG_DAT_W'($urandom));
			cfg_write(CFG_PAT_SEL, CFG_DAT_W'($urandom));
			cfg_write(CFG_PERIOD, {11'($urandom),
				(ph == 3) ? PERIOD_MAX : PERIOD_W'($urandom_range(1, 9))});
			cfg_we <= 1'b0;
			n_settings++;
			if (ph == 0)
				hold_armed = 1'b1;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				roll = $urandom_range(99);
				if (roll < 8) begin
					// stray items outside a frame
					send_item((roll < 4) ? MODE_NONE : MODE_END, 1'($urandom));
					if (roll >= 4)
						sent++;
				end else begin
					flen = $urandom_range(1, 10);
					repeat (flen) send_item(MODE_DATA, 1'($urandom));
					sent += flen;
					roll = $urandom_range(99);
					if (roll < 70) begin
						send_item(MODE_TERM, 1'($urandom));
						sent++;
					end else if (roll < 88) begin
						send_item(MODE_END, 1'($urandom));
						sent++;
					end
				end
			end
		end

		drain_results();
		$display("covered %0d input items over %0d register settings and four handshake phases",
			n_items, n_settings);
		$display("checked %0d results, %0d of them tail results", results_seen, tail_seen);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/rsc_pkg.sv
rtl/rsc_cell.sv
rtl/rsc_punct.sv
rtl/rsc_encoder_punctured_tail.sv
test/rsc_checker.sv
test/testbench.sv
